// File: design/sorted_priority_queue_unit_defines.svh
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    typedef struct packed {
        logic   insert_en;
        logic   delete_en;
        entry_t item;
    } cell_cmd_t;

endpackage

// File: design/spq_cell.sv
// One storage cell of the sorted row: holds an entry and shifts with its neighbors.
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      occupied,
    input  logic      left_gt,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output logic      gt,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;

    assign gt    = occupied && (entry_reg.prio > cmd.item.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.insert_en)
        begin
            priority if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || !occupied)
            begin
                entry_next = cmd.item;
            end
            else
            begin
                entry_next = entry_reg;
            end
        end
        else if (cmd.delete_en)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: design/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: a row of shifting cells and the result register.
//
//   Channel   Ports                                             Handshake
//   request   op, item_value, item_priority                     start, busy
//   result    status, removed_value, removed_priority,          done
//             occupancy
//
// A request is taken in every cycle; busy stays low.
// The result appears in the cycle after its request, for one cycle, with done high.
// The cells of the row all compare and shift in the same cycle.
// Reset empties the queue at once; stored entries are not cleared.
// The receiver cannot stall, so nothing holds results back.
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      op,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic [PRIO_W-1:0]         item_priority,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] removed_value,
    output logic [PRIO_W-1:0]         removed_priority,
    output logic [OCC_W-1:0]          occupancy
);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VALUE_W-1:0] removed_value_reg;
    logic signed [VALUE_W-1:0] removed_value_next;
    logic [PRIO_W-1:0]         removed_priority_reg;
    logic [PRIO_W-1:0]         removed_priority_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    cell_cmd_t                 cmd;
    entry_t                    cell_entry [DEPTH];
    logic [DEPTH-1:0]          cell_gt;
    logic [DEPTH-1:0]          cell_occupied;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    assign cmd.insert_en  = accept && (op == OP_INSERT) && !full;
    assign cmd.delete_en  = accept && (op == OP_DELETE) && !empty;
    assign cmd.item.value = item_value;
    assign cmd.item.prio  = item_priority;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t left_entry;
            entry_t right_entry;
            logic   left_gt;

            assign cell_occupied[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_entry = cmd.item;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_inner
                assign left_entry = cell_entry[i-1];
                assign left_gt    = cell_gt[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_entry = cell_entry[i];
            end
            else
            begin : g_body
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (cell_occupied[i]),
                .left_gt     (left_gt),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .gt          (cell_gt[i]),
                .entry       (cell_entry[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next            = count_reg;
        status_next           = ST_OK;
        removed_value_next    = '0;
        removed_priority_next = '0;
        unique case (op)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    count_next            = count_reg - CNT_W'(1);
                    removed_value_next    = cell_entry[0].value;
                    removed_priority_next = cell_entry[0].prio;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg           <= status_next;
            removed_value_reg    <= removed_value_next;
            removed_priority_reg <= removed_priority_next;
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign removed_value    = removed_value_reg;
    assign removed_priority = removed_priority_reg;
    assign occupancy        = OCC_W'(count_reg);

    `SPQ_ASSERT_NEXT(a_done_follows_request, accept, done, "result strobe missing after request")
    `SPQ_ASSERT_NEXT(a_no_spurious_done, !accept, !done, "result strobe without request")
    `SPQ_ASSERT_SAME(a_count_bounded, 1'b1, count_reg <= CNT_W'(DEPTH), "count exceeds depth")
    `SPQ_ASSERT_NEXT(a_delete_decrements, cmd.delete_en, count_reg == $past(count_reg) - CNT_W'(1), "delete did not shrink the queue")
    `SPQ_ASSERT_SAME(a_overflow_when_full, done && status == ST_OVERFLOW, full, "overflow reported while not full")
    `SPQ_ASSERT_SAME(a_head_sorted, cell_occupied[1], cell_entry[0].prio <= cell_entry[1].prio, "head entries out of order")

endmodule

// File: verif/testbench.sv
// Testbench for the sorted priority queue unit: directed and random requests checked against a queue model.
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    typedef struct {
        status_t                   status;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        logic [OCC_W-1:0]          occupancy;
    } queue_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      op;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         item_priority;
    logic                      done;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [PRIO_W-1:0]         removed_priority;
    logic [OCC_W-1:0]          occupancy;

    entry_t        model_entries [DEPTH];
    int            model_count;
    queue_result_t awaited_results [$];
    int            errors;
    int            idle_pct;

    sorted_priority_queue_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .item_value       (item_value),
        .item_priority    (item_priority),
        .done             (done),
        .status           (status),
        .removed_value    (removed_value),
        .removed_priority (removed_priority),
        .occupancy        (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic queue_result_t predict_queue_result(
        input logic                      req_op,
        input logic signed [VALUE_W-1:0] req_value,
        input logic [PRIO_W-1:0]         req_prio
    );
        queue_result_t res;
        int            pos;
        res.value = '0;
        res.prio  = '0;
        if (req_op == OP_INSERT)
        begin
            if (model_count >= DEPTH)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                pos = model_count;
                while (pos > 0 && model_entries[pos - 1].prio > req_prio)
                begin
                    model_entries[pos] = model_entries[pos - 1];
                    pos--;
                end
                model_entries[pos].value = req_value;
                model_entries[pos].prio  = req_prio;
                model_count++;
                res.status = ST_OK;
            end
        end
        else
        begin
            if (model_count == 0)
            begin
                res.status = ST_UNDERFLOW;
            end
            else
            begin
                res.value = model_entries[0].value;
                res.prio  = model_entries[0].prio;
                for (int k = 1; k < model_count; k++)
                begin
                    model_entries[k - 1] = model_entries[k];
                end
                model_count--;
                res.status = ST_OK;
            end
        end
        res.occupancy = OCC_W'(model_count);
        return res;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with no request waiting, expected none, actual status %0h",
                             $time, status);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    report_field("status", 32'(want.status), 32'(status));
                    report_field("removed_value", want.value, removed_value);
                    report_field("removed_priority", 32'(want.prio), 32'(removed_priority));
                    report_field("occupancy", 32'(want.occupancy), 32'(occupancy));
                end
            end
            if (start && !busy)
            begin
                awaited_results.push_back(predict_queue_result(op, item_value, item_priority));
            end
        end
    end

    task automatic send_request(
        input logic                      req_op,
        input logic signed [VALUE_W-1:0] req_value,
        input logic [PRIO_W-1:0]         req_prio
    );
        while ($urandom_range(99) < idle_pct)
        begin
            start         <= 1'b0;
            op            <= 1'($urandom_range(1));
            item_value    <= $urandom;
            item_priority <= 8'($urandom);
            @(negedge clk);
        end
        start         <= 1'b1;
        op            <= req_op;
        item_value    <= req_value;
        item_priority <= req_prio;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_until_idle();
        start <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PRIO_W-1:0] pick_priority(input int mode);
        case (mode)
            0: return 8'($urandom_range(3));
            1:
            begin
                case ($urandom_range(3))
                    0: return 8'd0;
                    1: return 8'd1;
                    2: return 8'd254;
                    default: return 8'd255;
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_extremes();
        send_request(OP_INSERT, 32'sh7FFF_FFFF, 8'd255);
        send_request(OP_INSERT, 32'sh8000_0000, 8'd0);
        send_request(OP_INSERT, 32'sh0000_0000, 8'd128);
        send_request(OP_INSERT, -1, 8'd255);
        send_request(OP_INSERT, 32'sh5555_AAAA, 8'd0);
        repeat (5) send_request(OP_DELETE, $urandom, 8'($urandom));
    endtask

    task automatic test_equal_priority_order();
        send_request(OP_INSERT, 32'sd11, 8'd7);
        send_request(OP_INSERT, 32'sd12, 8'd7);
        send_request(OP_INSERT, 32'sd13, 8'd3);
        send_request(OP_INSERT, 32'sd14, 8'd7);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_INSERT, 32'sd15, 8'd7);
        repeat (4) send_request(OP_DELETE, '0, '0);
    endtask

    task automatic test_empty_delete();
        send_request(OP_DELETE, 32'shFFFF_FFFF, 8'hFF);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_INSERT, 32'sd42, 8'd9);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_DELETE, '0, '0);
    endtask

    task automatic test_fill_overflow();
        int mode;
        mode = $urandom_range(2);
        repeat (DEPTH) send_request(OP_INSERT, pick_value(), pick_priority(mode));
        repeat (3) send_request(OP_INSERT, pick_value(), pick_priority(2));
        repeat (DEPTH + 2) send_request(OP_DELETE, pick_value(), pick_priority(2));
    endtask

    task automatic test_random_mix(input int count);
        int   insert_pct;
        int   mode;
        logic req_op;
        insert_pct = 50;
        mode       = 2;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                case ($urandom_range(2))
                    0: insert_pct = 10;
                    1: insert_pct = 50;
                    default: insert_pct = 90;
                endcase
                mode = $urandom_range(2);
            end
            req_op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
            send_request(req_op, pick_value(), pick_priority(mode));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_INSERT;
        item_value    = '0;
        item_priority = '0;
        model_count   = 0;
        errors        = 0;
        idle_pct      = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_equal_priority_order();
        test_empty_delete();
        wait_until_idle();

        test_random_mix(200);
        wait_until_idle();

        idle_pct = 52;
        test_fill_overflow();
        test_random_mix(200);
        wait_until_idle();

        idle_pct = 22;
        test_random_mix(200);
        wait_until_idle();

        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
